@@ sv/bdq_pkg.sv @@
// Shared types, sizes and helpers for the bounded deque with search.
// No dependencies; used by the core, the entry RAM wiring and the checker.
package bdq_pkg;

    localparam int CAPACITY    = 16;
    localparam int DATA_WIDTH  = 32;
    localparam int VALUE_WIDTH = 32;
    localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int OFF_W       = CNT_W + 1;

    typedef logic [IDX_W-1:0]       idx_t;
    typedef logic [CNT_W-1:0]       cnt_t;
    typedef logic [OFF_W-1:0]       off_t;
    typedef logic [DATA_WIDTH-1:0]  data_t;
    typedef logic [VALUE_WIDTH-1:0] value_t;

    typedef enum logic [2:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_BACK  = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_POP_BACK   = 3'd3,
        ACT_SEARCH     = 3'd4,
        ACT_DELETE     = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_EMPTY     = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POP,
        ST_SCAN,
        ST_MOVE,
        ST_FINISH
    } state_t;

    // ring position of (front + off); off stays within CAPACITY + 1 for every read or write address that is used
    function automatic idx_t ring_pos(idx_t front, off_t off);
        logic [OFF_W:0] s;
        s = (OFF_W + 1)'(front) + (OFF_W + 1)'(off);
        if (s >= (OFF_W + 1)'(CAPACITY))
            s = s - (OFF_W + 1)'(CAPACITY);
        return s[IDX_W-1:0];
    endfunction

    function automatic idx_t ring_prev(idx_t front);
        idx_t r;
        if (front == '0)
            r = idx_t'(CAPACITY - 1);
        else
            r = front - 1'b1;
        return r;
    endfunction

    // input value -> stored word (low DATA_WIDTH bits, zero filled above)
    function automatic data_t to_data(value_t v);
        data_t r;
        r = '0;
        for (int i = 0; i < DATA_WIDTH && i < VALUE_WIDTH; i++)
            r[i] = v[i];
        return r;
    endfunction

    // stored word -> popped value field
    function automatic value_t to_value(data_t d);
        value_t r;
        r = '0;
        for (int i = 0; i < DATA_WIDTH && i < VALUE_WIDTH; i++)
            r[i] = d[i];
        return r;
    endfunction

endpackage

@@ sv/bdq_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package dependency.
module bdq_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

@@ sv/bounded_deque_with_search_core.sv @@
// Bounded deque with search and delete-by-value, entries held in a ring in one RAM.
// Depends on bdq_pkg and bdq_ram.
//
//  channel | signals                                   | dir
//  --------+-------------------------------------------+----
//  in      | in_valid, in_ready, action, value         | in
//  out     | out_valid, out_ready, popped_value, found, | out
//          | status, occupancy                         |
//
// One request at a time. Pop makes one RAM read.
// Search: up to count entries, one entry compared per cycle off the RAM read port.
// Delete: scan, then one entry closed up per cycle.
// Result sits in an output register; the next request is taken while it waits.
// Reset clears front index, count and control; no clearing pass over the RAM.
module bounded_deque_with_search_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [2:0]                            action,
    input  logic signed [bdq_pkg::VALUE_WIDTH-1:0] value,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [bdq_pkg::VALUE_WIDTH-1:0] popped_value,
    output logic                                  found,
    output logic [1:0]                            status,
    output logic [bdq_pkg::CNT_W-1:0]             occupancy
);

    bdq_pkg::state_t  state_reg, state_next;
    bdq_pkg::idx_t    front_reg, front_next;
    bdq_pkg::cnt_t    count_reg, count_next;
    bdq_pkg::cnt_t    k_reg, k_next;
    bdq_pkg::action_t act_reg, act_next;
    bdq_pkg::data_t   val_reg, val_next;
    bdq_pkg::value_t  res_popped_reg, res_popped_next;
    logic             res_found_reg, res_found_next;
    bdq_pkg::status_t res_status_reg, res_status_next;
    logic             out_valid_reg, out_valid_next;
    bdq_pkg::value_t  out_popped_reg, out_popped_next;
    logic             out_found_reg, out_found_next;
    bdq_pkg::status_t out_status_reg, out_status_next;
    bdq_pkg::cnt_t    out_occ_reg, out_occ_next;

    logic             ram_we;
    bdq_pkg::idx_t    ram_waddr;
    bdq_pkg::data_t   ram_wdata;
    bdq_pkg::idx_t    ram_raddr;
    bdq_pkg::data_t   ram_rdata;

    bdq_pkg::action_t in_act;
    bdq_pkg::data_t   in_data;
    bdq_pkg::off_t    k_off;
    bdq_pkg::off_t    cnt_off;
    logic             is_full;
    logic             is_empty;
    logic             hit;
    logic             scan_last;
    logic             move_last;
    logic             out_free;

    assign in_act    = bdq_pkg::action_t'(action);
    assign in_data   = bdq_pkg::to_data(bdq_pkg::value_t'(value));
    assign k_off     = bdq_pkg::off_t'(k_reg);
    assign cnt_off   = bdq_pkg::off_t'(count_reg);
    assign is_full   = (count_reg == bdq_pkg::cnt_t'(bdq_pkg::CAPACITY));
    assign is_empty  = (count_reg == '0);
    assign hit       = (ram_rdata == val_reg);
    assign scan_last = ((k_off + bdq_pkg::off_t'(1)) >= cnt_off);
    assign move_last = ((k_off + bdq_pkg::off_t'(2)) >= cnt_off);
    assign out_free  = !out_valid_reg || out_ready;

    assign in_ready     = (state_reg == bdq_pkg::ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign popped_value = out_popped_reg;
    assign found        = out_found_reg;
    assign status       = out_status_reg;
    assign occupancy    = out_occ_reg;

    bdq_ram #(
        .WIDTH (bdq_pkg::DATA_WIDTH),
        .DEPTH (bdq_pkg::CAPACITY)
    ) u_entries (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bdq_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_act)
                        bdq_pkg::ACT_POP_FRONT,
                        bdq_pkg::ACT_POP_BACK:
                            state_next = is_empty ? bdq_pkg::ST_FINISH : bdq_pkg::ST_POP;
                        bdq_pkg::ACT_SEARCH,
                        bdq_pkg::ACT_DELETE:
                            state_next = is_empty ? bdq_pkg::ST_FINISH : bdq_pkg::ST_SCAN;
                        default:
                            state_next = bdq_pkg::ST_FINISH;
                    endcase
                end
            end
            bdq_pkg::ST_POP:
                state_next = bdq_pkg::ST_FINISH;
            bdq_pkg::ST_SCAN:
            begin
                if (hit)
                begin
                    if (act_reg == bdq_pkg::ACT_SEARCH || scan_last)
                        state_next = bdq_pkg::ST_FINISH;
                    else
                        state_next = bdq_pkg::ST_MOVE;
                end
                else if (scan_last)
                    state_next = bdq_pkg::ST_FINISH;
            end
            bdq_pkg::ST_MOVE:
            begin
                if (move_last)
                    state_next = bdq_pkg::ST_FINISH;
            end
            bdq_pkg::ST_FINISH:
            begin
                if (out_free)
                    state_next = bdq_pkg::ST_IDLE;
            end
            default:
                state_next = bdq_pkg::ST_IDLE;
        endcase
    end

    // datapath and RAM control
    always_comb
    begin
        front_next      = front_reg;
        count_next      = count_reg;
        k_next          = k_reg;
        act_next        = act_reg;
        val_next        = val_reg;
        res_popped_next = res_popped_reg;
        res_found_next  = res_found_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_popped_next = out_popped_reg;
        out_found_next  = out_found_reg;
        out_status_next = out_status_reg;
        out_occ_next    = out_occ_reg;
        ram_we          = 1'b0;
        ram_waddr       = front_reg;
        ram_wdata       = val_reg;
        // read one entry ahead of the compare / copy position
        ram_raddr       = bdq_pkg::ring_pos(front_reg, k_off + bdq_pkg::off_t'(1));

        case (state_reg)
            bdq_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    act_next        = in_act;
                    val_next        = in_data;
                    k_next          = '0;
                    res_popped_next = '0;
                    res_found_next  = 1'b0;
                    res_status_next = bdq_pkg::STAT_OK;
                    case (in_act)
                        bdq_pkg::ACT_PUSH_FRONT:
                        begin
                            if (is_full)
                                res_status_next = bdq_pkg::STAT_FULL;
                            else
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = bdq_pkg::ring_prev(front_reg);
                                ram_wdata  = in_data;
                                front_next = bdq_pkg::ring_prev(front_reg);
                                count_next = count_reg + 1'b1;
                            end
                        end
                        bdq_pkg::ACT_PUSH_BACK:
                        begin
                            if (is_full)
                                res_status_next = bdq_pkg::STAT_FULL;
                            else
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = bdq_pkg::ring_pos(front_reg, cnt_off);
                                ram_wdata  = in_data;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        bdq_pkg::ACT_POP_FRONT:
                        begin
                            ram_raddr = front_reg;
                            if (is_empty)
                                res_status_next = bdq_pkg::STAT_EMPTY;
                        end
                        bdq_pkg::ACT_POP_BACK:
                        begin
                            ram_raddr = bdq_pkg::ring_pos(front_reg,
                                                          cnt_off - bdq_pkg::off_t'(1));
                            if (is_empty)
                                res_status_next = bdq_pkg::STAT_EMPTY;
                        end
                        bdq_pkg::ACT_SEARCH:
                        begin
                            ram_raddr = front_reg;
                            if (is_empty)
                                res_status_next = bdq_pkg::STAT_NOT_FOUND;
                        end
                        bdq_pkg::ACT_DELETE:
                        begin
                            ram_raddr = front_reg;
                            if (is_empty)
                                res_status_next = bdq_pkg::STAT_EMPTY;
                        end
                        default:
                            res_status_next = bdq_pkg::STAT_OK;
                    endcase
                end
            end
            bdq_pkg::ST_POP:
            begin
                res_popped_next = bdq_pkg::to_value(ram_rdata);
                count_next      = count_reg - 1'b1;
                if (act_reg == bdq_pkg::ACT_POP_FRONT)
                    front_next = bdq_pkg::ring_pos(front_reg, bdq_pkg::off_t'(1));
            end
            bdq_pkg::ST_SCAN:
            begin
                if (hit)
                begin
                    res_found_next = 1'b1;
                    // match on the last entry: nothing to close up
                    if (act_reg == bdq_pkg::ACT_DELETE && scan_last)
                        count_next = count_reg - 1'b1;
                end
                else if (scan_last)
                    res_status_next = bdq_pkg::STAT_NOT_FOUND;
                else
                    k_next = k_reg + 1'b1;
            end
            bdq_pkg::ST_MOVE:
            begin
                // entry k+1 arrives now; write it to slot k, fetch k+2
                ram_we    = 1'b1;
                ram_waddr = bdq_pkg::ring_pos(front_reg, k_off);
                ram_wdata = ram_rdata;
                ram_raddr = bdq_pkg::ring_pos(front_reg, k_off + bdq_pkg::off_t'(2));
                if (move_last)
                    count_next = count_reg - 1'b1;
                else
                    k_next = k_reg + 1'b1;
            end
            bdq_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_popped_next = res_popped_reg;
                    out_found_next  = res_found_reg;
                    out_status_next = res_status_reg;
                    out_occ_next    = count_reg;
                end
            end
            default:
                ram_we = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bdq_pkg::ST_IDLE;
            front_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg          <= k_next;
        act_reg        <= act_next;
        val_reg        <= val_next;
        res_popped_reg <= res_popped_next;
        res_found_reg  <= res_found_next;
        res_status_reg <= res_status_next;
        out_popped_reg <= out_popped_next;
        out_found_reg  <= out_found_next;
        out_status_reg <= out_status_next;
        out_occ_reg    <= out_occ_next;
    end

endmodule

@@ sv/bdq_checker.sv @@
// Port-level checks for the bounded deque core, bound into the core module.
// Depends on bdq_pkg.
module bdq_checker (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  out_valid,
    input logic                                  out_ready,
    input logic signed [bdq_pkg::VALUE_WIDTH-1:0] popped_value,
    input logic                                  found,
    input logic [1:0]                            status,
    input logic [bdq_pkg::CNT_W-1:0]             occupancy
);

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> occupancy <= bdq_pkg::CNT_W'(bdq_pkg::CAPACITY))
        else $error("occupancy above capacity");

    a_full_means_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == bdq_pkg::STAT_FULL
            |-> occupancy == bdq_pkg::CNT_W'(bdq_pkg::CAPACITY) && !found)
        else $error("full status with room left");

    a_empty_means_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == bdq_pkg::STAT_EMPTY
            |-> occupancy == '0 && !found && popped_value == '0)
        else $error("empty status with entries held");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found |-> status == bdq_pkg::STAT_OK && popped_value == '0)
        else $error("found request with bad status");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(popped_value)
            && $stable(found) && $stable(status) && $stable(occupancy))
        else $error("stalled result changed");

endmodule

bind bounded_deque_with_search_core bdq_checker u_bdq_checker (.*);

@@ dv/tb_bounded_deque_with_search_core.sv @@
// Self-checking bench for bounded_deque_with_search_core: directed and random
// deque requests, predicted against a queue-based deque model. Needs bdq_pkg.
module tb_bounded_deque_with_search_core;
    timeunit 1ns;
    timeprecision 1ps;

    import bdq_pkg::*;

    localparam logic [2:0] ACT_SPARE_6 = 3'd6;
    localparam logic [2:0] ACT_SPARE_7 = 3'd7;
    localparam int         RANDOM_OPS  = 900;
    localparam int         IDLE_LIMIT  = 2000;
    localparam int         TAIL_CYCLES = 40;

    typedef enum int {
        PH_FILL,
        PH_DRAIN,
        PH_LOOKUP,
        PH_MIXED
    } mix_phase_t;

    typedef enum int {
        RX_ALWAYS,
        RX_COIN,
        RX_ONE_IN_FOUR,
        RX_SPARSE
    } rx_mode_t;

    typedef struct {
        logic [2:0]  act;
        value_t      val;
        int unsigned gap;
        bit          drain;
    } deque_req_t;

    typedef struct {
        value_t  popped;
        logic    found;
        status_t status;
        cnt_t    occ;
    } deque_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic [2:0]                    action = '0;
    logic signed [VALUE_WIDTH-1:0] value = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic signed [VALUE_WIDTH-1:0] popped_value;
    logic                          found;
    logic [1:0]                    status;
    logic [CNT_W-1:0]              occupancy;

    deque_req_t    pending_requests[$];
    deque_result_t expected_results[$];
    data_t         model_entries[$];
    deque_result_t got_result;
    int            fails = 0;

    int unsigned   in_flight;
    int unsigned   gap_left;
    int            pending_now;

    rx_mode_t      rx_mode;
    int unsigned   rx_mode_left;
    logic [1:0]    rx_tick;

    bounded_deque_with_search_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .value        (value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .popped_value (popped_value),
        .found        (found),
        .status       (status),
        .occupancy    (occupancy)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Deque model: front of the store is element 0 of model_entries.
    function automatic deque_result_t apply_deque_op(logic [2:0] act, value_t val);
        deque_result_t r;
        data_t         word;
        int            hit;
        r.popped = '0;
        r.found  = 1'b0;
        r.status = STAT_OK;
        word     = data_t'(val);
        hit      = -1;
        if (act == ACT_SEARCH || act == ACT_DELETE)
            for (int k = 0; k < model_entries.size(); k++)
                if (hit < 0 && model_entries[k] == word)
                    hit = k;
        case (act)
            ACT_PUSH_FRONT, ACT_PUSH_BACK:
            begin
                if (model_entries.size() >= CAPACITY)
                    r.status = STAT_FULL;
                else if (act == ACT_PUSH_FRONT)
                    model_entries.push_front(word);
                else
                    model_entries.push_back(word);
            end
            ACT_POP_FRONT, ACT_POP_BACK:
            begin
                if (model_entries.size() == 0)
                    r.status = STAT_EMPTY;
                else if (act == ACT_POP_FRONT)
                    r.popped = value_t'(model_entries.pop_front());
                else
                    r.popped = value_t'(model_entries.pop_back());
            end
            ACT_SEARCH:
            begin
                if (hit >= 0)
                    r.found = 1'b1;
                else
                    r.status = STAT_NOT_FOUND;
            end
            ACT_DELETE:
            begin
                if (model_entries.size() == 0)
                    r.status = STAT_EMPTY;
                else if (hit >= 0)
                begin
                    model_entries.delete(hit);
                    r.found = 1'b1;
                end
                else
                    r.status = STAT_NOT_FOUND;
            end
            default:
                ;
        endcase
        r.occ = cnt_t'(model_entries.size());
        return r;
    endfunction

    task automatic add_request(logic [2:0] act, value_t val, int unsigned gap, bit drain);
        deque_req_t q;
        q.act   = act;
        q.val   = val;
        q.gap   = gap;
        q.drain = drain;
        pending_requests.push_back(q);
    endtask

    // small pool so that searches and deletes hit, including duplicates
    function automatic value_t pick_value();
        value_t v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: v = value_t'($urandom_range(0, 7));
            5:             v = 32'h8000_0000;
            6:             v = 32'h7FFF_FFFF;
            default:       v = $urandom;
        endcase
        return v;
    endfunction

    // Driver: one request held until accepted; gaps and drain pauses taken between requests.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            action    <= '0;
            value     <= '0;
            in_flight <= 0;
            gap_left  <= 0;
        end
        else
        begin
            pending_now = int'(in_flight) + int'(in_valid && in_ready)
                        - int'(out_valid && out_ready);
            in_flight <= pending_now;
            if (!in_valid || in_ready)
            begin
                if (gap_left != 0)
                begin
                    in_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (pending_requests.size() != 0 && pending_requests[0].gap != 0)
                begin
                    in_valid <= 1'b0;
                    gap_left <= pending_requests[0].gap - 1;
                    pending_requests[0].gap = 0;
                end
                else if (pending_requests.size() != 0 &&
                         (!pending_requests[0].drain || pending_now == 0))
                begin
                    in_valid <= 1'b1;
                    action   <= pending_requests[0].act;
                    value    <= pending_requests[0].val;
                    void'(pending_requests.pop_front());
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver backpressure, switching among a few patterns.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready    <= 1'b0;
            rx_mode      <= RX_ALWAYS;
            rx_mode_left <= 0;
            rx_tick      <= '0;
        end
        else
        begin
            rx_tick <= rx_tick + 1'b1;
            if (rx_mode_left == 0)
            begin
                rx_mode      <= rx_mode_t'($urandom_range(0, 3));
                rx_mode_left <= $urandom_range(20, 120);
            end
            else
                rx_mode_left <= rx_mode_left - 1;
            case (rx_mode)
                RX_ALWAYS:      out_ready <= 1'b1;
                RX_COIN:        out_ready <= 1'($urandom_range(0, 1));
                RX_ONE_IN_FOUR: out_ready <= (rx_tick == 2'd0);
                default:        out_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // Monitor: check results against the oldest prediction, predict accepted requests.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result: popped_value %h found %b status %0d occupancy %0d",
                           popped_value, found, status, occupancy);
                    fails++;
                end
                else
                begin
                    got_result = expected_results.pop_front();
                    if (popped_value !== got_result.popped)
                    begin
                        $error("popped_value: expected %h, got %h",
                               got_result.popped, popped_value);
                        fails++;
                    end
                    if (found !== got_result.found)
                    begin
                        $error("found: expected %b, got %b", got_result.found, found);
                        fails++;
                    end
                    if (status !== got_result.status)
                    begin
                        $error("status: expected %0d, got %0d", got_result.status, status);
                        fails++;
                    end
                    if (occupancy !== got_result.occ)
                    begin
                        $error("occupancy: expected %0d, got %0d", got_result.occ, occupancy);
                        fails++;
                    end
                end
            end
            if (in_valid && in_ready)
                expected_results.push_back(apply_deque_op(action, value_t'(value)));
        end
    end

    // Watchdog on cycles with no handshake on either side.
    initial
    begin
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle = 0;
            else
                idle++;
        end
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        mix_phase_t  phase;
        int          phase_left;
        int          burst_left;
        int          quiet_left;
        int          counted;
        int unsigned roll;
        int unsigned gap;
        logic [2:0]  act;

        // empty-store corner cases and unused codes
        add_request(ACT_POP_FRONT,  32'd0,         0, 1'b0);
        add_request(ACT_POP_BACK,   32'hFFFF_FFFF, 0, 1'b0);
        add_request(ACT_DELETE,     32'd5,         0, 1'b0);
        add_request(ACT_SEARCH,     32'd0,         0, 1'b0);
        add_request(ACT_SPARE_6,    $urandom,      0, 1'b0);
        add_request(ACT_SPARE_7,    32'hFFFF_FFFF, 0, 1'b0);
        // extremes, then duplicates for first-occurrence delete
        add_request(ACT_PUSH_FRONT, 32'h8000_0000, 0, 1'b0);
        add_request(ACT_PUSH_BACK,  32'h7FFF_FFFF, 0, 1'b0);
        add_request(ACT_PUSH_FRONT, 32'd0,         0, 1'b0);
        add_request(ACT_PUSH_BACK,  32'hFFFF_FFFF, 0, 1'b0);
        add_request(ACT_PUSH_BACK,  32'd5,         0, 1'b0);
        add_request(ACT_PUSH_FRONT, 32'd5,         0, 1'b0);
        add_request(ACT_SEARCH,     32'd5,         0, 1'b0);
        add_request(ACT_SEARCH,     32'h7FFF_FFFF, 0, 1'b0);
        add_request(ACT_SEARCH,     32'd3,         0, 1'b0);
        add_request(ACT_DELETE,     32'd5,         0, 1'b0);
        add_request(ACT_DELETE,     32'd12345,     0, 1'b0);
        add_request(ACT_DELETE,     32'h7FFF_FFFF, 0, 1'b0);
        add_request(ACT_SPARE_6,    32'h8000_0000, 0, 1'b0);
        add_request(ACT_POP_BACK,   32'd0,         0, 1'b0);
        add_request(ACT_POP_FRONT,  32'd0,         0, 1'b0);
        add_request(ACT_POP_FRONT,  32'd0,         0, 1'b0);
        add_request(ACT_POP_BACK,   32'd0,         0, 1'b0);
        add_request(ACT_POP_BACK,   32'd0,         0, 1'b0);

        // random part: phases bias toward filling, draining or lookups
        phase      = PH_MIXED;
        phase_left = 0;
        burst_left = 0;
        quiet_left = 0;
        counted    = 0;
        while (counted < RANDOM_OPS)
        begin
            if (phase_left == 0)
            begin
                phase      = mix_phase_t'($urandom_range(0, 3));
                phase_left = $urandom_range(8, 48);
            end
            phase_left--;
            roll = $urandom_range(0, 99);
            if (roll < 3)
                act = $urandom_range(0, 1) ? ACT_SPARE_6 : ACT_SPARE_7;
            else
            begin
                case (phase)
                    PH_FILL:
                        act = (roll < 80) ? 3'($urandom_range(0, 1)) : 3'($urandom_range(2, 5));
                    PH_DRAIN:
                        act = (roll < 70) ? 3'($urandom_range(2, 3)) : 3'($urandom_range(0, 5));
                    PH_LOOKUP:
                        act = (roll < 48) ? ACT_SEARCH :
                              (roll < 83) ? ACT_DELETE : 3'($urandom_range(0, 1));
                    default:
                        act = 3'($urandom_range(0, 5));
                endcase
                counted++;
            end
            gap = 0;
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 24);
                if (quiet_left == 0 && $urandom_range(0, 9) == 0)
                    quiet_left = 60;
                if (quiet_left == 0)
                    gap = $urandom_range(1, 12);
            end
            burst_left--;
            if (quiet_left != 0)
                quiet_left--;
            add_request(act, pick_value(), gap,
                        (counted == 1) || ($urandom_range(0, 199) == 0));
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_requests.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fails == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ bounded_deque_with_search_core.f @@
sv/bdq_pkg.sv
sv/bdq_ram.sv
sv/bounded_deque_with_search_core.sv
sv/bdq_checker.sv
dv/tb_bounded_deque_with_search_core.sv
